### design/dll_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the linked list engine
// depends on nothing
package dll_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W     = 7;
    localparam int VAL_W     = 32;

    typedef enum logic [2:0] {
        FN_CLEAR    = 3'd0,
        FN_ADD_HEAD = 3'd1,
        FN_ADD_TAIL = 3'd2,
        FN_ADD_POS  = 3'd3,
        FN_FIND     = 3'd4,
        FN_REMOVE   = 3'd5,
        FN_LIST     = 3'd6,
        FN_REVERSE  = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_LIST
    } state_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_LOAD,
        CM_FROM_LEFT,
        CM_FROM_RIGHT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t        mode;
        logic [VAL_W-1:0]  load_value;
    } cell_ctrl_t;

endpackage

### design/dll_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and results
// depends on dll_pkg
interface dll_in_if
    import dll_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic signed [31:0] data_value;
    logic [6:0]        position;

    modport source (output valid, func, data_value, position, input ready);
    modport sink   (input valid, func, data_value, position, output ready);
endinterface

interface dll_out_if
    import dll_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic signed [31:0] item_value;
    logic [6:0]        found_position;
    logic [6:0]        element_count;
    logic              item_valid;
    logic              last;

    modport source (output valid, status, item_value, found_position, element_count,
                    item_valid, last, input ready);
    modport sink   (input valid, status, item_value, found_position, element_count,
                    item_valid, last, output ready);
endinterface

### design/dll_cell.sv
`timescale 1ns / 1ps
// one list slot: holds a value, shifts with its neighbors, compares to the key
// depends on dll_pkg
module dll_cell
    import dll_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [VAL_W-1:0] left_value,
    input  logic [VAL_W-1:0] right_value,
    input  logic [VAL_W-1:0] key,
    output logic [VAL_W-1:0] value,
    output logic             match
);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb
    begin
        case (ctrl.mode)
            CM_LOAD:       value_next = ctrl.load_value;
            CM_FROM_LEFT:  value_next = left_value;
            CM_FROM_RIGHT: value_next = right_value;
            default:       value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == key);

endmodule

### design/doubly_linked_list_engine.sv
`timescale 1ns / 1ps
// top level of the linked list engine: sequencer plus a row of list cells
// depends on dll_pkg, dll_if, dll_cell
//
//  channel | dir | transaction payload
//  --------+-----+---------------------------------------------------------------
//  req     | in  | func, data_value, position
//  rsp     | out | status, item_value, found_position, element_count, item_valid, last
//
// the list lives in positional order in a row of cells; insert and remove shift the
// cells after the target by one place, all cells together
// find and remove scan one cell per cycle
// listings emit one element per cycle while the output is free (one no-item result when empty)
// every result waits in an output register; a listing stalls and a finished scan holds while it is not taken
// reset clears count, pool usage and the sequencer; cell contents need no reset
module doubly_linked_list_engine
    import dll_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dll_in_if.sink     in_ch,
    dll_out_if.source  out_ch
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pool_reg, pool_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    func_t            func_reg, func_next;
    logic [VAL_W-1:0] key_reg, key_next;

    // output register
    logic             ov_reg, ov_next;
    status_t          ost_reg, ost_next;
    logic [VAL_W-1:0] oval_reg, oval_next;
    logic [CNT_W-1:0] opos_reg, opos_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;
    logic             oiv_reg, oiv_next;
    logic             olast_reg, olast_next;

    logic             out_free;
    logic             accept;
    func_t            in_func;
    logic             scan_end;
    logic             hit;
    logic             list_last;
    logic [CNT_W-1:0] ins_k;
    logic [CNT_W-1:0] pos_m1;
    logic             ins_en;
    logic             rm_en;

    cell_ctrl_t       ctrl    [POOL_SIZE];
    logic [VAL_W-1:0] cell_val[POOL_SIZE];
    logic [POOL_SIZE-1:0] match_vec;

    assign out_free = !ov_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign accept = in_ch.valid && in_ch.ready;
    assign in_func = func_t'(in_ch.func);

    assign scan_end  = (idx_reg == count_reg);
    assign hit       = !scan_end && match_vec[idx_reg[IDX_W-1:0]];
    assign list_last = (func_reg == FN_LIST) ? (idx_reg == count_reg - CNT_W'(1))
                                             : (idx_reg == '0);

    // insert slot: head, tail, or clamped 1-based position
    assign pos_m1 = in_ch.position - CNT_W'(1);
    always_comb
    begin
        case (in_func)
            FN_ADD_TAIL: ins_k = count_reg;
            FN_ADD_POS:  ins_k = (in_ch.position > CNT_W'(1))
                                 ? ((pos_m1 > count_reg) ? count_reg : pos_m1) : '0;
            default:     ins_k = '0;
        endcase
    end

    assign ins_en = accept && (pool_reg < CNT_W'(POOL_SIZE)) &&
                    (in_func == FN_ADD_HEAD || in_func == FN_ADD_TAIL ||
                     in_func == FN_ADD_POS);
    assign rm_en  = (state_reg == S_SEARCH) && hit && out_free && (func_reg == FN_REMOVE);

    // per-cell shift control
    always_comb
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            ctrl[i].load_value = in_ch.data_value;
            ctrl[i].mode       = CM_HOLD;
            if (ins_en)
            begin
                if (ins_k == CNT_W'(i))
                    ctrl[i].mode = CM_LOAD;
                else if (CNT_W'(i) > ins_k)
                    ctrl[i].mode = CM_FROM_LEFT;
            end
            else if (rm_en && CNT_W'(i) >= idx_reg)
            begin
                ctrl[i].mode = CM_FROM_RIGHT;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < POOL_SIZE; g++)
        begin : g_cell
            dll_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl[g]),
                .left_value  ((g == 0) ? in_ch.data_value : cell_val[(g == 0) ? 0 : g-1]),
                .right_value ((g == POOL_SIZE-1) ? cell_val[g]
                              : cell_val[(g == POOL_SIZE-1) ? g : g+1]),
                .key         (key_reg),
                .value       (cell_val[g]),
                .match       (match_vec[g])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == FN_FIND || in_func == FN_REMOVE)
                        state_next = S_SEARCH;
                    else if ((in_func == FN_LIST || in_func == FN_REVERSE) &&
                             count_reg != '0)
                        state_next = S_LIST;
                end
            end
            S_SEARCH:
            begin
                if ((hit || scan_end) && out_free)
                    state_next = S_IDLE;
            end
            S_LIST:
            begin
                if (out_free && list_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        count_next = count_reg;
        pool_next  = pool_reg;
        idx_next   = idx_reg;
        func_next  = func_reg;
        key_next   = key_reg;
        ov_next    = ov_reg && !out_ch.ready;
        ost_next   = ost_reg;
        oval_next  = oval_reg;
        opos_next  = opos_reg;
        ocnt_next  = ocnt_reg;
        oiv_next   = oiv_reg;
        olast_next = olast_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = in_func;
                    key_next  = in_ch.data_value;
                    idx_next  = (in_func == FN_REVERSE) ? count_reg - CNT_W'(1) : '0;
                    ost_next   = ST_OK;
                    oval_next  = '0;
                    opos_next  = '0;
                    oiv_next   = 1'b0;
                    olast_next = 1'b1;
                    ocnt_next  = count_reg;
                    case (in_func)
                        FN_CLEAR:
                        begin
                            count_next = '0;
                            pool_next  = '0;
                            ocnt_next  = '0;
                            ov_next    = 1'b1;
                        end
                        FN_ADD_HEAD, FN_ADD_TAIL, FN_ADD_POS:
                        begin
                            ov_next = 1'b1;
                            if (ins_en)
                            begin
                                count_next = count_reg + CNT_W'(1);
                                pool_next  = pool_reg + CNT_W'(1);
                                ocnt_next  = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ost_next = ST_FULL;
                            end
                        end
                        FN_LIST, FN_REVERSE:
                        begin
                            // empty list gives a single no-item result
                            ov_next = (count_reg == '0);
                        end
                        default: ov_next = ov_reg && !out_ch.ready;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (hit || scan_end)
                begin
                    if (out_free)
                    begin
                        ov_next    = 1'b1;
                        oval_next  = '0;
                        oiv_next   = 1'b0;
                        olast_next = 1'b1;
                        ost_next   = ST_OK;
                        opos_next  = '0;
                        ocnt_next  = count_reg;
                        if (func_reg == FN_FIND)
                            opos_next = idx_reg + CNT_W'(1);
                        else if (hit)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            ocnt_next  = count_reg - CNT_W'(1);
                        end
                        else
                            ost_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_OK;
                    oval_next  = cell_val[idx_reg[IDX_W-1:0]];
                    opos_next  = '0;
                    ocnt_next  = count_reg;
                    oiv_next   = 1'b1;
                    olast_next = list_last;
                    idx_next   = (func_reg == FN_LIST) ? idx_reg + CNT_W'(1)
                                                       : idx_reg - CNT_W'(1);
                end
            end
            default: ov_next = ov_reg && !out_ch.ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pool_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pool_reg  <= pool_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        func_reg  <= func_next;
        key_reg   <= key_next;
        ost_reg   <= ost_next;
        oval_reg  <= oval_next;
        opos_reg  <= opos_next;
        ocnt_reg  <= ocnt_next;
        oiv_reg   <= oiv_next;
        olast_reg <= olast_next;
    end

    assign out_ch.valid          = ov_reg;
    assign out_ch.status         = ost_reg;
    assign out_ch.item_value     = oval_reg;
    assign out_ch.found_position = opos_reg;
    assign out_ch.element_count  = ocnt_reg;
    assign out_ch.item_valid     = oiv_reg;
    assign out_ch.last           = olast_reg;

endmodule

### design/dll_checker.sv
`timescale 1ns / 1ps
// port-level checks of the linked list engine, bound to the top level
// depends on dll_pkg; the bind names doubly_linked_list_engine
module dll_checker
    import dll_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [6:0] found_position,
    input logic [6:0] element_count,
    input logic       item_valid,
    input logic       last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> element_count <= 7'(POOL_SIZE))
        else $error("element count beyond pool");

    a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_valid |-> status == ST_OK && found_position == '0)
        else $error("list element with bad status");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && !item_valid)
        else $error("error result not final");

endmodule

bind doubly_linked_list_engine dll_checker u_dll_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .found_position (out_ch.found_position),
    .element_count  (out_ch.element_count),
    .item_valid     (out_ch.item_valid),
    .last           (out_ch.last)
);
